// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 7;
  localparam int unsigned CapReset = 50;

  // APB register map: register i sits at byte address 4*i.
  localparam int unsigned PaddrW = 3;
  localparam logic RegCapacity = 1'b0;
  localparam logic RegMode     = 1'b1;

  localparam logic ModeInputRestricted  = 1'b0;
  localparam logic ModeOutputRestricted = 1'b1;

  typedef enum logic [1:0] {
    KIND_PUSH_REAR  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_OVERFLOW    = 2'd1,
    STATUS_UNDERFLOW   = 2'd2,
    STATUS_NOT_ALLOWED = 2'd3
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_READ = 1'b1
  } ctrl_state_e;

endpackage

// ===== rtl/core/deq_mem.sv =====
module deq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/deq_ctrl.sv =====
module deq_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [deq_pkg::CntW-1:0]   capacity_i,
  input  logic                       restrict_mode_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  deq_pkg::kind_e             kind_i,
  input  logic [deq_pkg::DataW-1:0]  push_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [deq_pkg::DataW-1:0]  pop_value_o,
  output deq_pkg::status_e           status_o,
  output logic [deq_pkg::CntW-1:0]   occupancy_o,
  output logic                       mem_we_o,
  output logic                       mem_re_o,
  output logic [$clog2(DEPTH)-1:0]   mem_addr_o,
  output logic [deq_pkg::DataW-1:0]  mem_wdata_o,
  input  logic [deq_pkg::DataW-1:0]  mem_rdata_i
);

  import deq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam int unsigned DepthLim = (DEPTH > 127) ? 127 : DEPTH;
  localparam logic [CntW-1:0] DepthLimC = CntW'(DepthLim);

  ctrl_state_e       state_q, state_d;
  logic [IdxW-1:0]   front_q, front_d;
  logic [IdxW-1:0]   rear_q, rear_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  pop_value_q, pop_value_d;
  status_e           status_q, status_d;
  logic [CntW-1:0]   occ_q, occ_d;

  logic [CntW-1:0]   limit;
  logic              slot_free;
  logic              accept;
  logic              not_allowed;
  logic              is_push;
  logic [IdxW-1:0]   front_next, front_prev, rear_next, rear_prev;

  assign limit = (capacity_i > DepthLimC) ? DepthLimC : capacity_i;
  // The output register is free after this edge if it is empty or being taken.
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == CTRL_IDLE) && slot_free;
  assign accept = in_valid_i && in_ready_o;

  assign not_allowed = ((kind_i == KIND_PUSH_FRONT) && (restrict_mode_i == ModeInputRestricted))
                    || ((kind_i == KIND_POP_REAR) && (restrict_mode_i == ModeOutputRestricted));
  assign is_push = (kind_i == KIND_PUSH_REAR) || (kind_i == KIND_PUSH_FRONT);

  assign front_next = (front_q == LastIdx) ? '0 : front_q + 1'b1;
  assign front_prev = (front_q == '0) ? LastIdx : front_q - 1'b1;
  assign rear_next  = (rear_q == LastIdx) ? '0 : rear_q + 1'b1;
  assign rear_prev  = (rear_q == '0) ? LastIdx : rear_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_value_d = pop_value_q;
    status_d    = status_q;
    occ_d       = occ_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = rear_q;
    mem_wdata_o = push_value_i;

    case (state_q)
      CTRL_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          pop_value_d = '0;
          status_d    = STATUS_OK;
          occ_d       = count_q;
          if (not_allowed) begin
            status_d = STATUS_NOT_ALLOWED;
          end else if (is_push && (count_q >= limit)) begin
            status_d = STATUS_OVERFLOW;
          end else if (!is_push && (count_q == '0)) begin
            status_d = STATUS_UNDERFLOW;
          end else begin
            case (kind_i)
              KIND_PUSH_REAR: begin
                mem_we_o   = 1'b1;
                mem_addr_o = rear_q;
                rear_d     = rear_next;
                count_d    = count_q + 1'b1;
                occ_d      = count_q + 1'b1;
              end
              KIND_PUSH_FRONT: begin
                mem_we_o   = 1'b1;
                mem_addr_o = front_prev;
                front_d    = front_prev;
                count_d    = count_q + 1'b1;
                occ_d      = count_q + 1'b1;
              end
              KIND_POP_FRONT: begin
                mem_re_o    = 1'b1;
                mem_addr_o  = front_q;
                front_d     = front_next;
                count_d     = count_q - 1'b1;
                out_valid_d = 1'b0;
                state_d     = CTRL_READ;
              end
              KIND_POP_REAR: begin
                mem_re_o    = 1'b1;
                mem_addr_o  = rear_prev;
                rear_d      = rear_prev;
                count_d     = count_q - 1'b1;
                out_valid_d = 1'b0;
                state_d     = CTRL_READ;
              end
              default: begin
                out_valid_d = 1'b1;
              end
            endcase
          end
        end
      end
      CTRL_READ: begin
        // Read data for the popped entry arrives now; the count is already updated.
        out_valid_d = 1'b1;
        pop_value_d = mem_rdata_i;
        status_d    = STATUS_OK;
        occ_d       = count_q;
        state_d     = CTRL_IDLE;
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_value_q <= pop_value_d;
    status_q    <= status_d;
    occ_q       <= occ_d;
  end

  assign out_valid_o = out_valid_q;
  assign pop_value_o = pop_value_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

endmodule

// ===== rtl/core/restricted_double_ended_queue_top.sv =====
// Bounded double-ended queue of signed 32-bit values held in a circular store.
// Requests enter on the input channel (in_valid_i / in_ready_o) with a kind
// (push rear, push front, pop front, pop rear) and a push value. Every request
// produces exactly one result transfer on the output channel (out_valid_o /
// out_ready_i) with the popped value, a status and the occupancy afterwards.
// Pushes and refused requests register their result at the accepting edge; a
// new request can be taken in the following cycle if that result is taken.
// A successful pop waits in the read state for the registered read of the
// entry memory; no request is taken while the read is outstanding.
// The output register holds a result until it is taken; a new request is
// accepted in the same cycle that the pending result is taken, and otherwise
// waits while the receiver stalls.
// The APB port holds capacity (address 0, reset 50) and the restriction mode
// (address 4, reset 0: no front push; 1: no rear pop). Write it only while idle.
// Reset empties the queue and clears the result valid flag but not the result data;
// memory contents are not cleared and are only read after having been written.
module restricted_double_ended_queue_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [deq_pkg::PaddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic signed [31:0]            push_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            pop_value_o,
  output logic [1:0]                    status_o,
  output logic [6:0]                    occupancy_o
);

  import deq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic [CntW-1:0]  capacity_q;
  logic             mode_q;
  logic             cfg_write;
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_addr;
  logic [DataW-1:0] mem_wdata, mem_rdata;
  logic [DataW-1:0] pop_value;
  status_e          status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CntW'(CapReset);
      mode_q     <= ModeInputRestricted;
    end else if (cfg_write) begin
      if (paddr[2] == RegCapacity) begin
        capacity_q <= pwdata[CntW-1:0];
      end else begin
        mode_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegCapacity: prdata = {{(32 - CntW){1'b0}}, capacity_q};
      RegMode:     prdata = {31'b0, mode_q};
      default:     prdata = '0;
    endcase
  end

  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .capacity_i     (capacity_q),
    .restrict_mode_i(mode_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_e'(kind_i)),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pop_value_o    (pop_value),
    .status_o       (status),
    .occupancy_o    (occupancy_o),
    .mem_we_o       (mem_we),
    .mem_re_o       (mem_re),
    .mem_addr_o     (mem_addr),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata)
  );

  deq_mem #(
    .DEPTH(DEPTH),
    .WIDTH(DataW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign pop_value_o = pop_value;
  assign status_o    = status;

endmodule
